>>> hdl/ehfm_pkg.sv
// Shared types and constants for the entity health flap monitor.
`timescale 1ns / 1ps
package ehfm_pkg;

	localparam int NUM_ENTITIES = 256;
	localparam int ENT_W        = (NUM_ENTITIES > 1) ? $clog2(NUM_ENTITIES) : 1;

	localparam logic [7:0] UNKNOWN_ENTITY = 8'hFF;

	typedef enum logic [1:0] {
		CMD_REPORT  = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_e;

	localparam logic [2:0] ST_BOOT    = 3'd0;
	localparam logic [2:0] ST_NORMAL  = 3'd1;
	localparam logic [2:0] ST_FAULT   = 3'd2;
	localparam logic [2:0] ST_ERROR   = 3'd3;
	localparam logic [2:0] ST_FAILURE = 3'd4;

	localparam logic [1:0] REG_TRANSITION_GAP = 2'd0;
	localparam logic [1:0] REG_MAX_TRANSITION = 2'd1;
	localparam logic [1:0] REG_REPORT_TIMEOUT = 2'd2;

	localparam logic [31:0] GAP_RESET     = 32'd4000;
	localparam logic [7:0]  MAX_TR_RESET  = 8'd3;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  entity;
		logic [2:0]  reported_state;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] prior_state;
		logic [2:0] current_state;
		logic       warn_transition;
		logic       warn_unstable;
		logic       stabilized;
		logic       raise_error;
		logic       not_normal_on_enable;
		logic       timed_out;
		logic       bad_entity;
		logic [8:0] monitored_count;
		logic [8:0] boot_count;
		logic [8:0] critical_count;
	} rsp_t;

	// One table entry; all-zero is the reset content.
	typedef struct packed {
		logic [2:0]  state;
		logic        monitored;
		logic [31:0] last_report_ms;
		logic [31:0] last_transition_ms;
		logic [7:0]  count;
	} entry_t;

endpackage

>>> hdl/ehfm_table.sv
// Entity table: synchronous RAM, per-entry valid bits and write-to-read forwarding.
`timescale 1ns / 1ps
module ehfm_table
	import ehfm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [ENT_W-1:0] rd_idx,
	input  logic             wr_en,
	input  logic [ENT_W-1:0] wr_idx,
	input  entry_t           wr_data,
	output entry_t           rd_data
);

	entry_t                  mem [NUM_ENTITIES];
	logic [NUM_ENTITIES-1:0] vld_q;
	entry_t                  rd_q;
	logic                    rd_vld_q;
	logic                    fwd_q;
	entry_t                  fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
		fwd_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
				// entry being written this edge: RAM returns stale data
				fwd_q    <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

>>> hdl/entity_health_flap_monitor.sv
// Top level: command decode, entry update and running totals of the health table.
`timescale 1ns / 1ps
// The accepted request is registered into the s1 stage, and done is registered from the s1 valid bit.
// Throughput: one request per cycle while busy is low; a table read in the accept cycle and the
// update with write-back in the next, back-to-back hits on one entity forwarded.
// Reset: busy is high during reset and clears at the next clock edge; table reads as
// all boot/unmonitored/zero through per-entry valid bits, so there is no clearing pass.
// Results cannot be stalled: done is high for exactly one cycle per request.
module entity_health_flap_monitor
	import ehfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic        busy_q;
	logic [31:0] gap_q;
	logic [7:0]  max_tr_q;
	logic [31:0] timeout_q;
	logic [8:0]  mon_tot_q;
	logic [8:0] boot_tot_q;
	logic [8:0] crit_tot_q;

	logic        v_s1;
	logic        bad_s1;
	logic [1:0]  cmd_s1;
	logic [ENT_W-1:0] idx_s1;
	logic [2:0]  rs_s1;
	logic [31:0] now_s1;

	logic        done_q;
	rsp_t        result_q;

	logic        accept;
	logic        bad_in;
	logic [2:0]  rs_in;
	entry_t      ent;
	entry_t      nxt;
	rsp_t        rsp;
	logic        wr_en;

	logic        note;
	logic [31:0] d_tr;
	logic [31:0] d_rep;
	logic [7:0]  cnt1;
	logic        rem_en;
	logic [2:0]  rem_st;
	logic        add_en;
	logic [2:0]  add_st;
	logic [8:0]  mon_nxt;
	logic [8:0]  boot_nxt;
	logic [8:0]  crit_nxt;

	assign accept = start && !busy_q;
	assign bad_in = (request.entity == UNKNOWN_ENTITY) ||
		({1'b0, request.entity} >= 9'(NUM_ENTITIES));
	assign rs_in  = (request.reported_state > ST_FAILURE) ? ST_FAILURE : request.reported_state;

	ehfm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && !bad_in),
		.rd_idx  (request.entity[ENT_W-1:0]),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (nxt),
		.rd_data (ent)
	);

	assign wr_en = v_s1 && !bad_s1;

	always_comb begin
		nxt    = ent;
		rsp    = '0;
		rem_en = 1'b0;
		rem_st = ent.state;
		add_en = 1'b0;
		add_st = ent.state;
		note   = ent.monitored && (ent.state != rs_s1);
		d_tr   = now_s1 - ent.last_transition_ms;
		d_rep  = now_s1 - ent.last_report_ms;
		cnt1   = ent.count;

		rsp.prior_state = ent.state;
		case (cmd_s1)
			CMD_REPORT: begin
				if (note) begin
					if (d_tr < gap_q) begin
						cnt1 = (ent.count == 8'hFF) ? ent.count : ent.count + 8'd1;
					end else begin
						cnt1 = 8'd0;
					end
					nxt.last_transition_ms = now_s1;
					rsp.warn_transition    = cnt1 < max_tr_q;
					rsp.warn_unstable      = cnt1 == max_tr_q;
				end
				// a report that records a transition never stabilizes, so only a quiet report can stabilize
				if (!note && (d_tr > gap_q) && (cnt1 > max_tr_q)) begin
					cnt1           = 8'd0;
					rsp.stabilized = 1'b1;
				end
				nxt.count          = cnt1;
				nxt.last_report_ms = now_s1;
				nxt.state          = rs_s1;
				rem_en             = ent.monitored;
				add_en             = ent.monitored;
				add_st             = rs_s1;
				rsp.raise_error    = note && (rs_s1 != ST_NORMAL) && (rs_s1 != ST_FAULT);
			end
			CMD_ENABLE: begin
				if (!ent.monitored) begin
					nxt.monitored            = 1'b1;
					add_en                   = 1'b1;
					rsp.not_normal_on_enable = ent.state != ST_NORMAL;
				end
			end
			CMD_DISABLE: begin
				if (ent.monitored) begin
					nxt.monitored = 1'b0;
					rem_en        = 1'b1;
				end
			end
			default: begin
				if ((d_rep > timeout_q) && (ent.state != ST_FAILURE)) begin
					nxt.state          = ST_FAILURE;
					nxt.last_report_ms = now_s1;
					rsp.timed_out      = ent.monitored;
					rem_en             = ent.monitored;
					add_en             = ent.monitored;
					add_st             = ST_FAILURE;
				end
			end
		endcase
		rsp.current_state = nxt.state;

		mon_nxt  = mon_tot_q - 9'(rem_en) + 9'(add_en);
		boot_nxt = boot_tot_q - 9'(rem_en && (rem_st == ST_BOOT))
			+ 9'(add_en && (add_st == ST_BOOT));
		crit_nxt = crit_tot_q
			- 9'(rem_en && (rem_st != ST_BOOT) && (rem_st != ST_NORMAL))
			+ 9'(add_en && (add_st != ST_BOOT) && (add_st != ST_NORMAL));

		if (bad_s1) begin
			rsp            = '0;
			rsp.bad_entity = 1'b1;
			mon_nxt        = mon_tot_q;
			boot_nxt       = boot_tot_q;
			crit_nxt       = crit_tot_q;
		end
		rsp.monitored_count = mon_nxt;
		rsp.boot_count      = boot_nxt;
		rsp.critical_count  = crit_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= request.command;
			idx_s1 <= request.entity[ENT_W-1:0];
			rs_s1  <= rs_in;
			now_s1 <= request.now_ms;
			bad_s1 <= bad_in;
		end
		if (v_s1) begin
			result_q <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			v_s1       <= 1'b0;
			done_q     <= 1'b0;
			mon_tot_q  <= '0;
			boot_tot_q <= '0;
			crit_tot_q <= '0;
			gap_q      <= GAP_RESET;
			max_tr_q   <= MAX_TR_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			busy_q <= 1'b0;
			v_s1   <= accept;
			done_q <= v_s1;
			if (v_s1) begin
				mon_tot_q  <= mon_nxt;
				boot_tot_q <= boot_nxt;
				crit_tot_q <= crit_nxt;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_TRANSITION_GAP: gap_q     <= cfg_wdata;
					REG_MAX_TRANSITION: max_tr_q  <= cfg_wdata[7:0];
					REG_REPORT_TIMEOUT: timeout_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hdl/ehfm_checker.sv
// Port-level checks for the entity health flap monitor, bound to the top level.
`timescale 1ns / 1ps
module ehfm_checker
	import ehfm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	// every accepted request yields exactly one result strobe on done
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 2))
		else $error("result strobe does not follow the request by two cycles");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.bad_entity) |-> (result.prior_state == ST_BOOT) &&
		(result.current_state == ST_BOOT) && !result.warn_transition &&
		!result.warn_unstable && !result.stabilized && !result.raise_error &&
		!result.not_normal_on_enable && !result.timed_out)
		else $error("rejected entity produced state or flags");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, result.boot_count} + {1'b0, result.critical_count} <=
		{1'b0, result.monitored_count}) && (result.monitored_count <= 9'd256))
		else $error("running totals inconsistent");

	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.timed_out) |-> (result.current_state == ST_FAILURE) &&
		(result.prior_state != ST_FAILURE))
		else $error("timeout without a move to failure");

endmodule

bind entity_health_flap_monitor ehfm_checker u_ehfm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
